// ----- src/i2cbs_pkg.sv -----
// Shared types, command codes and sequence lengths for the I2C master bit sequencer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package i2cbs_pkg;

    // Command codes as they arrive in the mode field.
    localparam logic [2:0] MODE_START     = 3'd0;
    localparam logic [2:0] MODE_STOP      = 3'd1;
    localparam logic [2:0] MODE_WRITE     = 3'd2;
    localparam logic [2:0] MODE_READ      = 3'd3;
    localparam logic [2:0] MODE_ACK_WRITE = 3'd4;
    localparam logic [2:0] MODE_ACK_READ  = 3'd5;

    // Width of the step counter and of the bytes on the bus.
    localparam int unsigned STEP_W = 5;
    localparam int unsigned BYTE_W = 8;

    // Default depth of the queue between the front and back ends.
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Active command, one-hot.
    typedef enum logic [5:0] {
        CMD_START     = 6'b000001,
        CMD_STOP      = 6'b000010,
        CMD_WRITE     = 6'b000100,
        CMD_READ      = 6'b001000,
        CMD_ACK_WRITE = 6'b010000,
        CMD_ACK_READ  = 6'b100000
    } t_cmd;

    // One input beat: a tick, perhaps carrying a command.
    typedef struct packed {
        logic              cmd_valid;
        logic [2:0]        mode;
        logic [BYTE_W-1:0] tx_byte;
        logic              ack_value;
        logic              sda_in;
    } t_tick;

    // One result beat.
    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_seen;
    } t_res;

    // A classified tick as it travels through the queue.
    typedef struct packed {
        logic              cmd_ok;
        t_cmd              cmd;
        logic [BYTE_W-1:0] load;
        logic              sda;
    } t_item;

    // Index of the last step of each command's pin sequence.
    function automatic logic [STEP_W-1:0] last_step(input t_cmd cmd);
        logic [STEP_W-1:0] v;
        begin
            case (cmd)
                CMD_START:     v = 5'd3;
                CMD_STOP:      v = 5'd2;
                CMD_WRITE:     v = 5'd23;
                CMD_READ:      v = 5'd24;
                CMD_ACK_WRITE: v = 5'd2;
                CMD_ACK_READ:  v = 5'd3;
                default:       v = 5'd3;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/i2cbs_front.sv -----
// Front end: classifies each tick beat into a queue item.
// Depends on i2cbs_pkg for the beat and item types and the command codes.
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_front (
    input  wire                 i_tick_valid,
    output logic                o_tick_ready,
    input  i2cbs_pkg::t_tick    i_tick,
    output logic                o_item_valid,
    input  wire                 i_item_ready,
    output i2cbs_pkg::t_item    o_item
);
    import i2cbs_pkg::*;

    // Handshake passes straight to the queue; the front holds no state.
    assign o_item_valid = i_tick_valid;
    assign o_tick_ready = i_item_ready;

    // Decode the mode, reject undefined codes and prepare the shift load.
    always_comb begin
        o_item.cmd_ok = 1'b0;
        o_item.cmd    = CMD_START;
        o_item.load   = '0;
        o_item.sda    = i_tick.sda_in;
        if (i_tick.cmd_valid && (i_tick.mode inside {[MODE_START:MODE_ACK_READ]})) begin
            o_item.cmd_ok = 1'b1;
        end
        case (i_tick.mode)
            MODE_START:     o_item.cmd = CMD_START;
            MODE_STOP:      o_item.cmd = CMD_STOP;
            MODE_WRITE: begin
                o_item.cmd  = CMD_WRITE;
                o_item.load = i_tick.tx_byte;
            end
            MODE_READ:      o_item.cmd = CMD_READ;
            MODE_ACK_WRITE: begin
                o_item.cmd  = CMD_ACK_WRITE;
                o_item.load = {i_tick.ack_value, {(BYTE_W-1){1'b0}}};
            end
            MODE_ACK_READ:  o_item.cmd = CMD_ACK_READ;
            default:        o_item.cmd = CMD_START;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/i2cbs_queue.sv -----
// Small register queue between the front and back ends.
// Depends on i2cbs_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_queue #(
    parameter int unsigned DEPTH = i2cbs_pkg::QUEUE_DEPTH_DEF  // 2 to 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_valid,
    output logic                o_push_ready,
    input  i2cbs_pkg::t_item    i_push,
    output logic                o_pop_valid,
    input  wire                 i_pop_ready,
    output i2cbs_pkg::t_item    o_pop
);
    import i2cbs_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop        = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointer and occupancy updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push;
        end
    end

    // Occupancy never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue occupancy beyond depth");

    // A lone push grows the queue by exactly one beat.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");

    // A lone pop shrinks the queue by exactly one beat.
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not follow a pop");

endmodule

`default_nettype wire

// ----- src/i2cbs_back.sv -----
// Back end: runs one pin step per queued tick and registers the result beat.
// Depends on i2cbs_pkg for the item, result and command types.
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_item_valid,
    output logic                o_item_ready,
    input  i2cbs_pkg::t_item    i_item,
    output logic                o_res_valid,
    input  wire                 i_res_ready,
    output i2cbs_pkg::t_res     o_res
);
    import i2cbs_pkg::*;

    // Sequencer state.
    t_cmd              r_cmd, n_cmd;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_phase, n_phase;
    logic              r_running, n_running;
    logic [BYTE_W-1:0] r_send, n_send;
    logic [BYTE_W-1:0] r_recv, n_recv;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_ack, n_ack;
    logic              n_done;

    // Result register.
    logic              r_out_valid;
    t_res              r_out;

    logic              pop;

    assign o_item_ready = !r_out_valid || i_res_ready;
    assign pop          = i_item_valid && o_item_ready;
    assign o_res_valid  = r_out_valid;
    assign o_res        = r_out;

    // One step of the active pin sequence.
    always_comb begin
        n_cmd     = r_cmd;
        n_step    = r_step;
        n_phase   = r_phase;
        n_running = r_running;
        n_send    = r_send;
        n_recv    = r_recv;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_ack     = r_ack;
        n_done    = 1'b0;

        // Take a new command only when idle.
        if (!r_running && i_item.cmd_ok) begin
            n_cmd     = i_item.cmd;
            n_step    = '0;
            n_phase   = '0;
            n_running = 1'b1;
            if (i_item.cmd == CMD_WRITE || i_item.cmd == CMD_ACK_WRITE) begin
                n_send = i_item.load;
            end
            if (i_item.cmd == CMD_READ) begin
                n_recv = '0;
            end
        end

        if (n_running) begin
            case (n_cmd)
                CMD_START: begin
                    if (n_step == 5'd0)      n_sda = 1'b1;
                    else if (n_step == 5'd1) n_scl = 1'b1;
                    else if (n_step == 5'd2) n_sda = 1'b0;
                    else                     n_scl = 1'b0;
                end
                CMD_STOP: begin
                    if (n_step == 5'd0)      n_sda = 1'b0;
                    else if (n_step == 5'd1) n_scl = 1'b1;
                    else                     n_sda = 1'b1;
                end
                CMD_WRITE: begin
                    if (n_phase == 2'd0) begin
                        n_sda = n_send[BYTE_W-1];
                    end else if (n_phase == 2'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl  = 1'b0;
                        n_send = {n_send[BYTE_W-2:0], 1'b0};
                    end
                end
                CMD_READ: begin
                    // Release SDA first, then clock in eight bits.
                    if (n_step == 5'd0) begin
                        n_sda = 1'b1;
                    end else if (n_phase == 2'd0) begin
                        n_scl = 1'b1;
                    end else if (n_phase == 2'd1) begin
                        n_recv = {n_recv[BYTE_W-2:0], i_item.sda};
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                CMD_ACK_WRITE: begin
                    if (n_step == 5'd0)      n_sda = n_send[BYTE_W-1];
                    else if (n_step == 5'd1) n_scl = 1'b1;
                    else                     n_scl = 1'b0;
                end
                CMD_ACK_READ: begin
                    if (n_step == 5'd0)      n_sda = 1'b1;
                    else if (n_step == 5'd1) n_scl = 1'b1;
                    else if (n_step == 5'd2) n_ack = i_item.sda;
                    else                     n_scl = 1'b0;
                end
                default: begin
                    n_scl = r_scl;
                end
            endcase

            // Bit phase advances on every step except the read's release step.
            if (!(n_cmd == CMD_READ && n_step == 5'd0)) begin
                n_phase = (n_phase == 2'd2) ? 2'd0 : n_phase + 1'b1;
            end

            // Finish on the last step of the sequence.
            if (n_step == last_step(n_cmd)) begin
                n_running = 1'b0;
                n_step    = '0;
                n_done    = 1'b1;
            end else begin
                n_step = n_step + 1'b1;
            end
        end
    end

    // Control state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= CMD_START;
            r_step      <= '0;
            r_phase     <= '0;
            r_running   <= 1'b0;
            r_send      <= '0;
            r_recv      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_cmd     <= n_cmd;
                r_step    <= n_step;
                r_phase   <= n_phase;
                r_running <= n_running;
                r_send    <= n_send;
                r_recv    <= n_recv;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_ack     <= n_ack;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each executed beat.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.scl_level <= n_scl;
            r_out.sda_level <= n_sda;
            r_out.busy_res  <= n_running;
            r_out.done_res  <= n_done;
            r_out.rx_byte   <= n_recv;
            r_out.ack_seen  <= n_ack;
        end
    end

    // A running sequence never goes past its last step.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_step <= last_step(r_cmd)))
        else $error("step counter past end of sequence");

    // The step counter rests at zero while idle.
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_step == '0))
        else $error("step counter not cleared when idle");

    // The bit phase only counts through three values.
    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("bit phase out of range");

    // A finishing beat never also reports busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("result shows done and busy together");

endmodule

`default_nettype wire

// ----- src/i2c_master_bit_sequencer.sv -----
// I2C master bit sequencer: one tick beat in, one result beat out, one pin step per tick.
// An accepted tick passes through the queue and then the result register on its way to its result beat.
// Throughput: one tick per cycle while the result side does not stall, set by the single-step execute stage.
// Either side may stall; the queue and result register keep the other side moving.
// Reset (synchronous, active low) empties the queue, idles the sequencer and releases SCL/SDA.
// Depends on i2cbs_pkg, i2cbs_front, i2cbs_queue and i2cbs_back.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_sequencer #(
    parameter int unsigned QUEUE_DEPTH = i2cbs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_tick_valid,
    output logic                o_tick_ready,
    input  i2cbs_pkg::t_tick    i_tick,
    output logic                o_res_valid,
    input  wire                 i_res_ready,
    output i2cbs_pkg::t_res     o_res
);
    import i2cbs_pkg::*;

    logic  front_valid, front_ready;
    t_item front_item;
    logic  back_valid, back_ready;
    t_item back_item;

    // Classify incoming ticks.
    i2cbs_front u_front (
        .i_tick_valid (i_tick_valid),
        .o_tick_ready (o_tick_ready),
        .i_tick       (i_tick),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready),
        .o_item       (front_item)
    );

    // Decouple front and back.
    i2cbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push       (front_item),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop        (back_item)
    );

    // Execute pin steps and register results.
    i2cbs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (back_valid),
        .o_item_ready (back_ready),
        .i_item       (back_item),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

// ----- bench/i2c_master_bit_sequencer_check.sv -----
// Checker for the I2C master bit sequencer: watches both channels, predicts every result beat
// from the accepted tick beats and compares them field by field in arrival order.
// Depends on i2cbs_pkg for the beat types and the command codes.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_check (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_tick_valid,
    input  wire                 i_tick_ready,
    input  i2cbs_pkg::t_tick    i_tick,
    input  wire                 i_res_valid,
    input  wire                 i_res_ready,
    input  i2cbs_pkg::t_res     i_res,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count,
    output int                  o_done_count
);
    import i2cbs_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Our own copy of the sequencer state.
    logic [2:0]        bus_cmd;
    logic [STEP_W-1:0] bus_step;
    logic              bus_running;
    logic [BYTE_W-1:0] out_shift;
    logic [BYTE_W-1:0] in_shift;
    logic              scl_q;
    logic              sda_q;
    logic              ack_q;

    // Result beats predicted but not yet seen, oldest first.
    t_res due_results[$];

    int fail_total;
    int result_total;
    int done_total;
    int shown;

    // Number of pin steps in each command's sequence.
    function automatic int steps_of(input logic [2:0] m);
        case (m)
            MODE_START:     return 4;
            MODE_STOP:      return 3;
            MODE_WRITE:     return 24;
            MODE_READ:      return 25;
            MODE_ACK_WRITE: return 3;
            default:        return 4;
        endcase
    endfunction

    // Advances the pin sequence by one tick and gives the result beat it produces.
    task automatic step_pins(input t_tick t, output t_res r);
        logic done;
        int   phase;
        done = 1'b0;

        // A new command is taken only while idle and only for a defined mode.
        if (!bus_running && t.cmd_valid && t.mode <= MODE_ACK_READ) begin
            bus_cmd     = t.mode;
            bus_step    = '0;
            bus_running = 1'b1;
            if (t.mode == MODE_WRITE) begin
                out_shift = t.tx_byte;
            end else if (t.mode == MODE_ACK_WRITE) begin
                out_shift = {t.ack_value, 7'b0};
            end
            if (t.mode == MODE_READ) begin
                in_shift = '0;
            end
        end

        if (bus_running) begin
            case (bus_cmd)
                MODE_START: begin
                    case (bus_step)
                        0:       sda_q = 1'b1;
                        1:       scl_q = 1'b1;
                        2:       sda_q = 1'b0;
                        default: scl_q = 1'b0;
                    endcase
                end
                MODE_STOP: begin
                    case (bus_step)
                        0:       sda_q = 1'b0;
                        1:       scl_q = 1'b1;
                        default: sda_q = 1'b1;
                    endcase
                end
                MODE_WRITE: begin
                    phase = int'(bus_step) % 3;
                    if (phase == 0) begin
                        sda_q = out_shift[BYTE_W-1];
                    end else if (phase == 1) begin
                        scl_q = 1'b1;
                    end else begin
                        scl_q     = 1'b0;
                        out_shift = out_shift << 1;
                    end
                end
                MODE_READ: begin
                    // SDA is released first, then each bit is clock high, sample, clock low.
                    if (bus_step == 0) begin
                        sda_q = 1'b1;
                    end else begin
                        phase = (int'(bus_step) - 1) % 3;
                        if (phase == 0) begin
                            scl_q = 1'b1;
                        end else if (phase == 1) begin
                            in_shift = {in_shift[BYTE_W-2:0], t.sda_in};
                        end else begin
                            scl_q = 1'b0;
                        end
                    end
                end
                MODE_ACK_WRITE: begin
                    case (bus_step)
                        0:       sda_q = out_shift[BYTE_W-1];
                        1:       scl_q = 1'b1;
                        default: scl_q = 1'b0;
                    endcase
                end
                default: begin
                    case (bus_step)
                        0:       sda_q = 1'b1;
                        1:       scl_q = 1'b1;
                        2:       ack_q = t.sda_in;
                        default: scl_q = 1'b0;
                    endcase
                end
            endcase

            bus_step = bus_step + 1'b1;
            if (int'(bus_step) >= steps_of(bus_cmd)) begin
                bus_running = 1'b0;
                bus_step    = '0;
                done        = 1'b1;
            end
        end

        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res  = bus_running;
        r.done_res  = done;
        r.rx_byte   = in_shift;
        r.ack_seen  = ack_q;
    endtask

    // Compare arriving result beats first, then predict for an accepted tick beat.
    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            bus_cmd      = MODE_START;
            bus_step     = '0;
            bus_running  = 1'b0;
            out_shift    = '0;
            in_shift     = '0;
            scl_q        = 1'b1;
            sda_q        = 1'b1;
            ack_q        = 1'b1;
            fail_total   = 0;
            result_total = 0;
            done_total   = 0;
            shown        = 0;
            due_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                result_total++;
                if (due_results.size() == 0) begin
                    fail_total++;
                    if (shown < REPORT_LIMIT) begin
                        shown++;
                        $display("%0t: result beat %0d arrived with none expected", $time,
                                 result_total);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (want.done_res) begin
                        done_total++;
                    end
                    if (i_res.scl_level !== want.scl_level ||
                        i_res.sda_level !== want.sda_level ||
                        i_res.busy_res  !== want.busy_res  ||
                        i_res.done_res  !== want.done_res  ||
                        i_res.rx_byte   !== want.rx_byte   ||
                        i_res.ack_seen  !== want.ack_seen) begin
                        fail_total++;
                        if (shown < REPORT_LIMIT) begin
                            shown++;
                            $display("%0t: result beat %0d mismatch", $time, result_total);
                            $display("    expected scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                                     want.scl_level, want.sda_level, want.busy_res,
                                     want.done_res, want.rx_byte, want.ack_seen);
                            $display("    got scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                                     i_res.scl_level, i_res.sda_level, i_res.busy_res,
                                     i_res.done_res, i_res.rx_byte, i_res.ack_seen);
                        end
                    end
                end
            end
            if (i_tick_valid && i_tick_ready) begin
                step_pins(i_tick, want);
                due_results.push_back(want);
            end
        end
        o_fail_count   <= fail_total;
        o_pending      <= due_results.size();
        o_result_count <= result_total;
        o_done_count   <= done_total;
    end

endmodule

// ----- bench/i2c_master_bit_sequencer_test.sv -----
// Testbench top for the I2C master bit sequencer: drives tick beats, stalls the result side
// at random and gives the verdict. Depends on i2cbs_pkg, the block and the checker module.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_test;
    import i2cbs_pkg::*;

    localparam int         TICK_TARGET   = 1850;
    localparam int         MAX_IDLE      = 18;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 10;
    localparam logic [2:0] MODE_TOP      = '1;

    logic  i_clk      = 1'b0;
    logic  i_rst_n    = 1'b0;
    logic  tick_valid = 1'b0;
    t_tick tick_beat  = '0;
    logic  tick_ready;
    logic  res_valid;
    logic  res_ready  = 1'b0;
    t_res  res_beat;

    int fail_count;
    int pending;
    int result_count;
    int done_count;

    // When set, both sides run without idling.
    bit steady = 1'b0;

    int ticks_sent     = 0;
    int cmds_sent      = 0;
    int undefined_sent = 0;
    int quiet_run      = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    i2c_master_bit_sequencer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (tick_valid),
        .o_tick_ready (tick_ready),
        .i_tick       (tick_beat),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res_beat)
    );

    i2c_master_bit_sequencer_check pin_watch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick_valid   (tick_valid),
        .i_tick_ready   (tick_ready),
        .i_tick         (tick_beat),
        .i_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .i_res          (res_beat),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_done_count   (done_count)
    );

    function automatic int idle_cycles();
        return steady ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Ticks a command needs, counting the one that carries it.
    function automatic int pin_steps(input logic [2:0] m);
        case (m)
            MODE_START:     return 4;
            MODE_STOP:      return 3;
            MODE_WRITE:     return 24;
            MODE_READ:      return 25;
            MODE_ACK_WRITE: return 3;
            default:        return 4;
        endcase
    endfunction

    // Bytes lean towards all zeros and all ones now and then.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // A tick with random content; a noisy one sometimes carries a command of any mode.
    function automatic t_tick random_tick(input bit noisy);
        t_tick t;
        t.cmd_valid = noisy && ($urandom_range(0, 11) == 0);
        t.mode      = 3'($urandom_range(0, MODE_TOP));
        t.tx_byte   = pick_byte();
        t.ack_value = 1'($urandom);
        t.sda_in    = 1'($urandom);
        return t;
    endfunction

    // Offers one tick beat after a random gap and holds it until accepted.
    task automatic drive_tick(input t_tick t);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_valid <= 1'b1;
        tick_beat  <= t;
        do @(posedge i_clk); while (!tick_ready);
        ticks_sent++;
        if (t.cmd_valid) begin
            if (t.mode <= MODE_ACK_READ) begin
                cmds_sent++;
            end else begin
                undefined_sent++;
            end
        end
    endtask

    // A command tick followed by plain ticks that carry the sequence along.
    task automatic issue_command(input logic [2:0] m, input logic [BYTE_W-1:0] tx,
                                 input logic ackv, input int fillers, input bit noisy);
        t_tick t;
        t           = random_tick(1'b0);
        t.cmd_valid = 1'b1;
        t.mode      = m;
        t.tx_byte   = tx;
        t.ack_value = ackv;
        drive_tick(t);
        repeat (fillers) drive_tick(random_tick(noisy));
    endtask

    // Result side: a random stall before each beat, none at all in steady stretches.
    initial begin : result_side
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ready <= 1'b1;
            do @(posedge i_clk); while (!res_valid);
        end
    end

    // Watchdog: too long without any beat moving on either channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_valid && tick_ready) || (res_valid && res_ready)) begin
            quiet_run <= 0;
        end else if (quiet_run >= STALL_LIMIT) begin
            $display("i2c_master_bit_sequencer_test: FAIL");
            $finish;
        end else begin
            quiet_run <= quiet_run + 1;
        end
    end

    initial begin : stimulus
        t_tick       t;
        logic [2:0]  m;
        int          fill;
        int          pick;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: an idle tick and both undefined modes while idle.
        t           = '0;
        t.tx_byte   = '1;
        t.sda_in    = 1'b1;
        drive_tick(t);
        t.cmd_valid = 1'b1;
        t.mode      = MODE_TOP;
        drive_tick(t);
        t.mode      = MODE_TOP - 1'b1;
        drive_tick(t);

        // Start condition, with a write byte arriving mid-sequence that must be ignored.
        issue_command(MODE_START, '0, 1'b0, 0, 1'b0);
        t           = '0;
        t.cmd_valid = 1'b1;
        t.mode      = MODE_WRITE;
        t.tx_byte   = 8'hA5;
        drive_tick(t);
        drive_tick('0);
        drive_tick('0);

        // Read acknowledge that samples a low SDA on its third step.
        issue_command(MODE_ACK_READ, '0, 1'b0, 0, 1'b0);
        t        = '0;
        t.sda_in = 1'b1;
        drive_tick(t);
        t.sda_in = 1'b0;
        drive_tick(t);
        t.sda_in = 1'b1;
        drive_tick(t);

        // Write acknowledge with both levels, then a stop condition.
        issue_command(MODE_ACK_WRITE, '1, 1'b1, 2, 1'b0);
        issue_command(MODE_ACK_WRITE, '0, 1'b0, 2, 1'b0);
        issue_command(MODE_STOP, '0, 1'b0, 2, 1'b0);
        drive_tick('0);

        // Random: mostly whole sequences with random content, some noise and cut-short runs.
        while (ticks_sent < TICK_TARGET) begin
            if ($urandom_range(0, 29) == 0) begin
                steady = !steady;
            end
            pick = $urandom_range(0, 19);
            if (pick < 16) begin
                m    = 3'($urandom_range(int'(MODE_START), int'(MODE_ACK_READ)));
                fill = pin_steps(m) - 1;
                if ($urandom_range(0, 9) == 0) begin
                    fill = $urandom_range(0, fill);
                end
                issue_command(m, pick_byte(), 1'($urandom), fill + $urandom_range(0, 2),
                              1'b1);
            end else if (pick < 18) begin
                repeat ($urandom_range(1, 4)) drive_tick(random_tick(1'b0));
            end else begin
                t           = random_tick(1'b0);
                t.cmd_valid = 1'b1;
                t.mode      = 3'($urandom_range(int'(MODE_ACK_READ) + 1, int'(MODE_TOP)));
                drive_tick(t);
            end
        end
        tick_valid <= 1'b0;

        // Drain: wait for every predicted beat, then keep watching for stray beats.
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Drove %0d tick beats, %0d with a defined command and %0d with an undefined one.",
                 ticks_sent, cmds_sent, undefined_sent);
        $display("Compared %0d result beats covering %0d finished commands; %0d mismatches.",
                 result_count, done_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("i2c_master_bit_sequencer_test: PASS");
        end else begin
            $display("i2c_master_bit_sequencer_test: FAIL");
        end
        $finish;
    end

endmodule

// ----- i2c_master_bit_sequencer.f -----
src/i2cbs_pkg.sv
src/i2cbs_front.sv
src/i2cbs_queue.sv
src/i2cbs_back.sv
src/i2c_master_bit_sequencer.sv
bench/i2c_master_bit_sequencer_check.sv
bench/i2c_master_bit_sequencer_test.sv
